/* hw/rtl/xme_pkg.sv */
// ----------------------------------------------------------------------------
// xme_pkg: shared types and constants of the ModRM instruction encoder
// Byte slots of one encoded instruction, prefix and field codes.
// ----------------------------------------------------------------------------
package xme_pkg;

  localparam int NUM_SLOTS = 13;

  // fixed byte slots; a mask bit marks which ones are sent
  localparam int SLOT_OSZ    = 0;
  localparam int SLOT_REX    = 1;
  localparam int SLOT_OPCODE = 2;
  localparam int SLOT_MODRM  = 3;
  localparam int SLOT_SIB    = 4;
  localparam int SLOT_DISP   = 5;
  localparam int SLOT_IMM    = 9;

  localparam logic [7:0] PREFIX_OSZ = 8'h66;
  localparam logic [7:0] REX_BASE   = 8'h40;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  localparam logic [2:0] RM_SIB      = 3'd4;
  localparam logic [2:0] RM_BP       = 3'd5;
  localparam logic [2:0] INDEX_NONE  = 3'd4;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  localparam logic [1:0] IMM_NONE = 2'd0;
  localparam logic [1:0] IMM_8    = 2'd1;
  localparam logic [1:0] IMM_32   = 2'd2;
  // unused kind, sends no immediate
  localparam logic [1:0] IMM_RSVD = 2'd3;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]      mask;
    logic [NUM_SLOTS-1:0][7:0] bytes;
  } enc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/xme_front.sv */
// ----------------------------------------------------------------------------
// xme_front: request intake and classification
// Accepts a request and lays out every byte of its encoding in fixed slots.
// ----------------------------------------------------------------------------
module xme_front import xme_pkg::*; (
  input  logic              start,
  input  q_status_t         q_status,
  input  logic [7:0]        base_opcode,
  input  logic [3:0]        reg_or_subop,
  input  logic              rm_is_register,
  input  logic [3:0]        base_reg,
  input  logic [3:0]        index_reg,
  input  logic [3:0]        scale_factor,
  input  logic signed [31:0] displacement,
  input  logic [1:0]        width_code,
  input  logic [1:0]        imm_kind,
  input  logic [31:0]       immediate,
  output logic              busy,
  output logic              push,
  output enc_t              enc
);

  logic        has_index;
  logic        w64;
  logic        xbit;
  logic        need_rex;
  logic [31:0] disp_biased;
  logic        disp_small;
  logic [1:0]  mod;
  logic [2:0]  rm;
  logic [1:0]  ss;
  logic [2:0]  idx;

  assign busy = q_status.full;
  assign push = start && !q_status.full;

  assign has_index   = !rm_is_register && (scale_factor != 4'd0);
  assign w64         = (width_code == WIDTH_64);
  assign xbit        = has_index && index_reg[3];
  assign need_rex    = w64 || reg_or_subop[3] || xbit || base_reg[3];
  assign disp_biased = $unsigned(displacement) + 32'd128;
  assign disp_small  = (disp_biased[31:8] == 24'd0);
  assign idx         = has_index ? index_reg[2:0] : INDEX_NONE;

  always_comb begin
    if (rm_is_register) begin
      mod = MOD_REG;
    end else if (displacement != 32'sd0 || base_reg[2:0] == RM_BP) begin
      mod = disp_small ? MOD_DISP8 : MOD_DISP32;
    end else begin
      mod = MOD_NODISP;
    end
  end

  always_comb begin
    if (!rm_is_register && has_index) begin
      rm = RM_SIB;
    end else begin
      rm = base_reg[2:0];
    end
  end

  always_comb begin
    ss = 2'd0;
    if (has_index) begin
      case (scale_factor)
        4'd2:    ss = 2'd1;
        4'd4:    ss = 2'd2;
        4'd8:    ss = 2'd3;
        default: ss = 2'd0;
      endcase
    end
  end

  always_comb begin
    enc = '0;
    enc.bytes[SLOT_OSZ]    = PREFIX_OSZ;
    enc.mask[SLOT_OSZ]     = (width_code == WIDTH_16);
    enc.bytes[SLOT_REX]    = REX_BASE | {4'd0, w64, reg_or_subop[3], xbit, base_reg[3]};
    enc.mask[SLOT_REX]     = need_rex;
    enc.bytes[SLOT_OPCODE] = base_opcode | {7'd0, (width_code != WIDTH_8)};
    enc.mask[SLOT_OPCODE]  = 1'b1;
    enc.bytes[SLOT_MODRM]  = {mod, reg_or_subop[2:0], rm};
    enc.mask[SLOT_MODRM]   = 1'b1;
    enc.bytes[SLOT_SIB]    = {ss, idx, base_reg[2:0]};
    enc.mask[SLOT_SIB]     = !rm_is_register && (rm == RM_SIB);
    for (int i = 0; i < 4; i++) begin
      enc.bytes[SLOT_DISP+i] = displacement[8*i +: 8];
      enc.bytes[SLOT_IMM+i]  = immediate[8*i +: 8];
    end
    // disp8 sends the low byte only, disp32 all four
    enc.mask[SLOT_DISP]      = (mod == MOD_DISP8) || (mod == MOD_DISP32);
    enc.mask[SLOT_DISP+1]    = (mod == MOD_DISP32);
    enc.mask[SLOT_DISP+2]    = (mod == MOD_DISP32);
    enc.mask[SLOT_DISP+3]    = (mod == MOD_DISP32);
    enc.mask[SLOT_IMM]       = (imm_kind == IMM_8) || (imm_kind == IMM_32);
    enc.mask[SLOT_IMM+1]     = (imm_kind == IMM_32);
    enc.mask[SLOT_IMM+2]     = (imm_kind == IMM_32);
    enc.mask[SLOT_IMM+3]     = (imm_kind == IMM_32);
  end

endmodule

/* hw/rtl/xme_queue.sv */
// ----------------------------------------------------------------------------
// xme_queue: request queue between intake and serializer
// Small register FIFO of laid-out encodings; DEPTH from 2 upward.
// ----------------------------------------------------------------------------
module xme_queue import xme_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  enc_t      push_data,
  input  logic      pop,
  output enc_t      pop_data,
  output q_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  enc_t             entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/xme_back.sv */
// ----------------------------------------------------------------------------
// xme_back: byte serializer
// Sends the marked slots of the current encoding, one byte per cycle.
// ----------------------------------------------------------------------------
module xme_back import xme_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  q_status,
  input  enc_t       q_data,
  output logic       pop,
  output logic       strobe,
  output logic [7:0] code_byte,
  output logic       last_byte
);

  logic [NUM_SLOTS-1:0]      cur_mask;
  logic [NUM_SLOTS-1:0][7:0] cur_bytes;
  logic                      active;
  logic [NUM_SLOTS-1:0]      lowest;
  logic [NUM_SLOTS-1:0]      rest;
  logic [7:0]                sel_byte;

  assign active = (cur_mask != '0);
  assign lowest = cur_mask & (~cur_mask + 1'b1);
  assign rest   = cur_mask & ~lowest;
  // load the next request as soon as the current one is on its last byte
  assign pop    = !q_status.empty && (!active || rest == '0);

  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sel_byte = sel_byte | ({8{lowest[i]}} & cur_bytes[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      strobe    <= 1'b0;
      last_byte <= 1'b0;
    end else begin
      if (pop) begin
        cur_mask <= q_data.mask;
      end else begin
        cur_mask <= rest;
      end
      strobe    <= active;
      last_byte <= active && (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_bytes <= q_data.bytes;
    end
    code_byte <= sel_byte;
  end

endmodule

/* hw/rtl/x86_modrm_instruction_encoder_unit.sv */
// When the unit is idle, an accepted request is written into the queue, loaded into
// the serializer and its first byte registered out. The serializer sets throughput: each
// request takes its length, 2 to 13 bytes, one byte per cycle, queued ones with no gap.
// busy rises only while the request queue is full; results cannot be stalled.
// Synchronous reset empties the queue and the serializer and drops strobe.
// ----------------------------------------------------------------------------
// x86_modrm_instruction_encoder_unit: ModRM-form x86-64 instruction encoder
// Intake lays out prefix, REX, opcode, ModRM, SIB, displacement and immediate;
// a queue decouples it from the serializer that sends the bytes.
// ----------------------------------------------------------------------------
module x86_modrm_instruction_encoder_unit import xme_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        base_opcode,
  input  logic [3:0]        reg_or_subop,
  input  logic              rm_is_register,
  input  logic [3:0]        base_reg,
  input  logic [3:0]        index_reg,
  input  logic [3:0]        scale_factor,
  input  logic signed [31:0] displacement,
  input  logic [1:0]        width_code,
  input  logic [1:0]        imm_kind,
  input  logic [31:0]       immediate,
  output logic              strobe,
  output logic [7:0]        code_byte,
  output logic              last_byte
);

  q_status_t q_status;
  enc_t      push_data;
  enc_t      pop_data;
  logic      push;
  logic      pop;

  xme_front u_front (
    .start          (start),
    .q_status       (q_status),
    .base_opcode    (base_opcode),
    .reg_or_subop   (reg_or_subop),
    .rm_is_register (rm_is_register),
    .base_reg       (base_reg),
    .index_reg      (index_reg),
    .scale_factor   (scale_factor),
    .displacement   (displacement),
    .width_code     (width_code),
    .imm_kind       (imm_kind),
    .immediate      (immediate),
    .busy           (busy),
    .push           (push),
    .enc            (push_data)
  );

  xme_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  xme_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (pop_data),
    .pop       (pop),
    .strobe    (strobe),
    .code_byte (code_byte),
    .last_byte (last_byte)
  );

endmodule

/* hw/rtl/xme_checker.sv */
// ----------------------------------------------------------------------------
// xme_checker: port-level checks of the instruction encoder
// Watches reset, byte framing and queue backpressure over time.
// ----------------------------------------------------------------------------
module xme_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic strobe,
  input logic last_byte
);

  // reset drops the result strobe and frees the request port
  assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("strobe or busy set after reset");

  // last marker only rides on a sent byte
  assert property (@(posedge clk) disable iff (rst) last_byte |-> strobe)
    else $error("last_byte without strobe");

  // bytes of one instruction come without gaps
  assert property (@(posedge clk) disable iff (rst) strobe && !last_byte |=> strobe)
    else $error("gap inside an instruction");

  // a full queue means the serializer is sending
  assert property (@(posedge clk) disable iff (rst) busy |=> strobe)
    else $error("busy while serializer idle");

endmodule

bind x86_modrm_instruction_encoder_unit xme_checker u_xme_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .strobe    (strobe),
  .last_byte (last_byte)
);

/* tb/sv/modrm_encoding_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modrm_encoding_checker: byte-stream checker for the ModRM instruction encoder
// Captures each accepted request and predicts its encoded bytes. Compares every
// strobed byte and its last marker, in order, against that prediction.
// ----------------------------------------------------------------------------
module modrm_encoding_checker import xme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [7:0]  base_opcode,
  input  logic [3:0]  reg_or_subop,
  input  logic        rm_is_register,
  input  logic [3:0]  base_reg,
  input  logic [3:0]  index_reg,
  input  logic [3:0]  scale_factor,
  input  logic [31:0] displacement,
  input  logic [1:0]  width_code,
  input  logic [1:0]  imm_kind,
  input  logic [31:0] immediate,
  input  logic        strobe,
  input  logic [7:0]  code_byte,
  input  logic        last_byte,
  output logic [31:0] fail_count,
  output logic [31:0] pending_bytes,
  output logic [31:0] bytes_checked
);

  localparam logic [3:0] SCALE_X2 = 4'd2;
  localparam logic [3:0] SCALE_X4 = 4'd4;
  localparam logic [3:0] SCALE_X8 = 4'd8;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } enc_byte_t;

  enc_byte_t expected_bytes[$];

  initial begin
    fail_count    = '0;
    pending_bytes = '0;
    bytes_checked = '0;
  end

  function automatic void encode_modrm_insn(
    input logic [7:0]  opc,
    input logic [3:0]  regop,
    input logic        direct,
    input logic [3:0]  base,
    input logic [3:0]  index,
    input logic [3:0]  scale,
    input logic [31:0] disp,
    input logic [1:0]  wcode,
    input logic [1:0]  ikind,
    input logic [31:0] imm
  );
    logic [7:0] insn[$];
    logic       has_index;
    logic       rex_w;
    logic       rex_x;
    logic [1:0] mod_f;
    logic [2:0] rm_f;
    logic [1:0] ss;
    logic [2:0] idx_f;
    logic       short_disp;
    int         k;

    has_index  = !direct && (scale != 4'd0);
    rex_w      = (wcode == WIDTH_64);
    rex_x      = has_index ? index[3] : 1'b0;
    short_disp = ($signed(disp) >= -128) && ($signed(disp) <= 127);

    if (wcode == WIDTH_16)
      insn.push_back(PREFIX_OSZ);
    if (rex_w || regop[3] || rex_x || base[3])
      insn.push_back(REX_BASE | {4'd0, rex_w, regop[3], rex_x, base[3]});
    insn.push_back(opc | {7'd0, wcode != WIDTH_8});

    if (direct) begin
      insn.push_back({MOD_REG, regop[2:0], base[2:0]});
    end else begin
      mod_f = MOD_NODISP;
      rm_f  = base[2:0];
      // a BP-like base has no zero-displacement form
      if (disp != 32'd0 || rm_f == RM_BP)
        mod_f = short_disp ? MOD_DISP8 : MOD_DISP32;
      if (has_index)
        rm_f = RM_SIB;
      insn.push_back({mod_f, regop[2:0], rm_f});
      if (rm_f == RM_SIB) begin
        ss    = 2'd0;
        idx_f = has_index ? index[2:0] : INDEX_NONE;
        if (has_index) begin
          if (scale == SCALE_X2)      ss = 2'd1;
          else if (scale == SCALE_X4) ss = 2'd2;
          else if (scale == SCALE_X8) ss = 2'd3;
        end
        insn.push_back({ss, idx_f, base[2:0]});
      end
      if (mod_f == MOD_DISP8) begin
        insn.push_back(disp[7:0]);
      end else if (mod_f == MOD_DISP32) begin
        for (k = 0; k < 4; k++)
          insn.push_back(disp[8*k +: 8]);
      end
    end

    if (ikind == IMM_8) begin
      insn.push_back(imm[7:0]);
    end else if (ikind == IMM_32) begin
      for (k = 0; k < 4; k++)
        insn.push_back(imm[8*k +: 8]);
    end

    for (k = 0; k < insn.size(); k++)
      expected_bytes.push_back('{code: insn[k], last: (k == insn.size() - 1)});
  endfunction

  always @(posedge clk) begin : watch
    enc_byte_t head;
    if (rst) begin
      expected_bytes.delete();
      pending_bytes <= '0;
    end else begin
      // compare before pushing, so a stray byte never meets a fresh request
      if (strobe) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b, nothing expected",
                   $time, code_byte, last_byte);
          fail_count <= fail_count + 1;
        end else begin
          head = expected_bytes.pop_front();
          if (head.code !== code_byte || head.last !== last_byte) begin
            $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                     $time, head.code, head.last, code_byte, last_byte);
            fail_count <= fail_count + 1;
          end
        end
        bytes_checked <= bytes_checked + 1;
      end
      if (start && !busy)
        encode_modrm_insn(base_opcode, reg_or_subop, rm_is_register, base_reg,
                          index_reg, scale_factor, displacement, width_code,
                          imm_kind, immediate);
      pending_bytes <= expected_bytes.size();
    end
  end

endmodule

/* tb/sv/tb_x86_modrm_instruction_encoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x86_modrm_instruction_encoder_unit: testbench of the ModRM encoder
// Sends directed corner-case instructions, then random ones with random gaps,
// and lets the byte checker compare every emitted byte with its prediction.
// ----------------------------------------------------------------------------
module tb_x86_modrm_instruction_encoder_unit;
  import xme_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_INSNS = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  base_opcode = '0;
  logic [3:0]  reg_or_subop = '0;
  logic        rm_is_register = 1'b0;
  logic [3:0]  base_reg = '0;
  logic [3:0]  index_reg = '0;
  logic [3:0]  scale_factor = '0;
  logic [31:0] displacement = '0;
  logic [1:0]  width_code = '0;
  logic [1:0]  imm_kind = '0;
  logic [31:0] immediate = '0;
  logic        strobe;
  logic [7:0]  code_byte;
  logic        last_byte;

  logic [31:0] fail_count;
  logic [31:0] pending_bytes;
  logic [31:0] bytes_checked;

  int cycles = 0;
  int insns_sent = 0;
  bit no_idle = 1'b0;

  x86_modrm_instruction_encoder_unit uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .base_opcode    (base_opcode),
    .reg_or_subop   (reg_or_subop),
    .rm_is_register (rm_is_register),
    .base_reg       (base_reg),
    .index_reg      (index_reg),
    .scale_factor   (scale_factor),
    .displacement   (displacement),
    .width_code     (width_code),
    .imm_kind       (imm_kind),
    .immediate      (immediate),
    .strobe         (strobe),
    .code_byte      (code_byte),
    .last_byte      (last_byte)
  );

  modrm_encoding_checker encoding_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .base_opcode    (base_opcode),
    .reg_or_subop   (reg_or_subop),
    .rm_is_register (rm_is_register),
    .base_reg       (base_reg),
    .index_reg      (index_reg),
    .scale_factor   (scale_factor),
    .displacement   (displacement),
    .width_code     (width_code),
    .imm_kind       (imm_kind),
    .immediate      (immediate),
    .strobe         (strobe),
    .code_byte      (code_byte),
    .last_byte      (last_byte),
    .fail_count     (fail_count),
    .pending_bytes  (pending_bytes),
    .bytes_checked  (bytes_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles, pending_bytes);
      $display("FAIL x86_modrm_instruction_encoder_unit");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic issue_insn(
    input logic [7:0]  opc,
    input logic [3:0]  regop,
    input logic        direct,
    input logic [3:0]  base,
    input logic [3:0]  index,
    input logic [3:0]  scale,
    input logic [31:0] disp,
    input logic [1:0]  wcode,
    input logic [1:0]  ikind,
    input logic [31:0] imm
  );
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    base_opcode    <= opc;
    reg_or_subop   <= regop;
    rm_is_register <= direct;
    base_reg       <= base;
    index_reg      <= index;
    scale_factor   <= scale;
    displacement   <= disp;
    width_code     <= wcode;
    imm_kind       <= ikind;
    immediate      <= imm;
    start          <= 1'b1;
    // hold the request until the unit takes it
    do @(posedge clk); while (busy);
    insns_sent++;
  endtask

  task automatic issue_random_insn();
    logic [3:0]  base;
    logic [3:0]  scale;
    logic [31:0] disp;
    base = 4'($urandom_range(0, 15));
    // favor the SP-like and BP-like bases
    if ($urandom_range(0, 3) == 0)
      base = {$urandom_range(0, 1) == 1, 1'b1, 1'b0, $urandom_range(0, 1) == 1};
    case ($urandom_range(0, 9))
      0, 1:    scale = 4'd0;
      2:       scale = 4'd1;
      3:       scale = 4'd2;
      4:       scale = 4'd4;
      5:       scale = 4'd8;
      default: scale = 4'($urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 5))
      0:       disp = 32'd0;
      1:       disp = $urandom_range(0, 255) - 128;
      2: begin
        case ($urandom_range(0, 3))
          0:       disp = 32'd127;
          1:       disp = 32'd128;
          2:       disp = -32'sd128;
          default: disp = -32'sd129;
        endcase
      end
      default: disp = $urandom;
    endcase
    issue_insn(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
               $urandom_range(0, 3) == 0, base, 4'($urandom_range(0, 15)), scale, disp,
               2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // register-direct forms, shortest and with REX.W, R and B
    issue_insn(8'h00, 4'd0, 1'b1, 4'd0, 4'd0, 4'd0, 32'd0, WIDTH_8, IMM_NONE, 32'd0);
    issue_insn(8'hFF, 4'd15, 1'b1, 4'd15, 4'd0, 4'd0, 32'd0, WIDTH_64, IMM_32, 32'hFFFF_FFFF);
    issue_insn(8'h80, 4'd7, 1'b1, 4'd3, 4'd0, 4'd0, 32'd0, WIDTH_16, IMM_8, 32'h0000_00A5);
    // index, scale and displacement ignored for a direct operand
    issue_insn(8'h88, 4'd2, 1'b1, 4'd9, 4'd15, 4'd8, 32'h8000_0000, WIDTH_32, IMM_NONE, 32'd0);
    // memory: no displacement, BP-like and R13 bases, SP-like base
    issue_insn(8'h8A, 4'd1, 1'b0, 4'd0, 4'd0, 4'd0, 32'd0, WIDTH_32, IMM_NONE, 32'd0);
    issue_insn(8'h8A, 4'd1, 1'b0, 4'd5, 4'd0, 4'd0, 32'd0, WIDTH_8, IMM_NONE, 32'd0);
    issue_insn(8'h8A, 4'd9, 1'b0, 4'd13, 4'd0, 4'd0, 32'd0, WIDTH_64, IMM_NONE, 32'd0);
    issue_insn(8'h00, 4'd0, 1'b0, 4'd4, 4'd0, 4'd0, 32'd0, WIDTH_8, IMM_NONE, 32'd0);
    issue_insn(8'h00, 4'd3, 1'b0, 4'd12, 4'd0, 4'd0, 32'd127, WIDTH_64, IMM_8, 32'd1);
    // displacement boundaries
    issue_insn(8'h30, 4'd4, 1'b0, 4'd1, 4'd0, 4'd0, -32'sd128, WIDTH_32, IMM_NONE, 32'd0);
    issue_insn(8'h30, 4'd4, 1'b0, 4'd1, 4'd0, 4'd0, 32'd128, WIDTH_32, IMM_NONE, 32'd0);
    issue_insn(8'h30, 4'd4, 1'b0, 4'd1, 4'd0, 4'd0, -32'sd129, WIDTH_32, IMM_NONE, 32'd0);
    issue_insn(8'h30, 4'd4, 1'b0, 4'd6, 4'd0, 4'd0, 32'h7FFF_FFFF, WIDTH_16, IMM_NONE, 32'd0);
    issue_insn(8'h30, 4'd4, 1'b0, 4'd7, 4'd0, 4'd0, 32'h8000_0000, WIDTH_8, IMM_NONE, 32'd0);
    // each listed scale, some unlisted ones, and index ignored when scale is zero
    issue_insn(8'h01, 4'd0, 1'b0, 4'd2, 4'd8, 4'd1, 32'd0, WIDTH_32, IMM_NONE, 32'd0);
    issue_insn(8'h01, 4'd0, 1'b0, 4'd2, 4'd15, 4'd2, 32'd4, WIDTH_32, IMM_NONE, 32'd0);
    issue_insn(8'h01, 4'd0, 1'b0, 4'd5, 4'd4, 4'd4, 32'd0, WIDTH_32, IMM_NONE, 32'd0);
    issue_insn(8'h01, 4'd0, 1'b0, 4'd4, 4'd7, 4'd8, 32'd0, WIDTH_64, IMM_NONE, 32'd0);
    issue_insn(8'h01, 4'd0, 1'b0, 4'd3, 4'd11, 4'd3, 32'd0, WIDTH_32, IMM_NONE, 32'd0);
    issue_insn(8'h01, 4'd0, 1'b0, 4'd3, 4'd11, 4'd15, 32'd0, WIDTH_32, IMM_NONE, 32'd0);
    issue_insn(8'h01, 4'd0, 1'b0, 4'd12, 4'd15, 4'd0, 32'd0, WIDTH_32, IMM_NONE, 32'd0);
    // immediate kind three carries no immediate
    issue_insn(8'hC6, 4'd0, 1'b1, 4'd1, 4'd0, 4'd0, 32'd0, WIDTH_8, IMM_RSVD, 32'hDEAD_BEEF);
    // longest encoding: prefix, REX, opcode, ModRM, SIB, disp32, imm32
    issue_insn(8'h80, 4'd8, 1'b0, 4'd13, 4'd9, 4'd8, 32'h1234_5678, WIDTH_16, IMM_32,
               32'h89AB_CDEF);

    for (int n = 0; n < RANDOM_INSNS; n++) begin
      // every third stretch of sixteen runs back to back
      no_idle = ((n / 16) % 3) == 2;
      issue_random_insn();
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d instructions, checked %0d bytes across all widths, register",
             insns_sent, bytes_checked);
    $display("and memory operands, every scale, displacement size and immediate kind");
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("PASS x86_modrm_instruction_encoder_unit");
    end else begin
      $display("FAIL x86_modrm_instruction_encoder_unit");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/xme_pkg.sv
hw/rtl/xme_front.sv
hw/rtl/xme_queue.sv
hw/rtl/xme_back.sv
hw/rtl/x86_modrm_instruction_encoder_unit.sv
hw/rtl/xme_checker.sv
tb/sv/modrm_encoding_checker.sv
tb/sv/tb_x86_modrm_instruction_encoder_unit.sv
